### rtl/core/mbe_pkg.sv
// shared types and constants for the mandelbrot escape-time pixel core
// no dependencies

package mbe_pkg;

   localparam int MAX_SIDE_DEF       = 4096;
   localparam int MAX_ITERATIONS_DEF = 4096;

   localparam int COORD_W     = 12;
   localparam int SIDE_W      = 13;
   localparam int COUNT_W     = 13;
   localparam int RADIUS_W    = 29;
   localparam int WIN_W       = 31;
   localparam int Q_W         = 32;
   localparam int GREY_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_col;
      logic [COORD_W-1:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] iteration_count;
      logic [GREY_W-1:0]  grey_level;
      logic               inside_set;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_W-1:0]        image_width;
      logic [SIDE_W-1:0]        image_height;
      logic [COUNT_W-1:0]       iteration_limit;
      logic [RADIUS_W-1:0]      escape_radius;
      logic signed [WIN_W-1:0]  real_min;
      logic signed [WIN_W-1:0]  real_max;
      logic signed [WIN_W-1:0]  imag_min;
      logic signed [WIN_W-1:0]  imag_max;
   } cfg_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_ITERATION_LIMIT = 3'd2,
      CSR_ESCAPE_RADIUS   = 3'd3,
      CSR_REAL_MIN        = 3'd4,
      CSR_REAL_MAX        = 3'd5,
      CSR_IMAG_MIN        = 3'd6,
      CSR_IMAG_MAX        = 3'd7
   } csr_index_type;

   localparam cfg_type CFG_RESET = '{
      image_width:     13'd1000,
      image_height:    13'd1000,
      iteration_limit: 13'd50,
      escape_radius:   29'd167772160,
      real_min:        -31'sd33554432,
      real_max:        31'sd33554432,
      imag_min:        -31'sd33554432,
      imag_max:        31'sd33554432
   };

   // mapped point of one pixel, signed q8.24
   typedef struct packed {
      logic signed [Q_W-1:0] c_re;
      logic signed [Q_W-1:0] c_im;
   } job_type;

endpackage

### rtl/core/mbe_front.sv
// front end: accepts a pixel request and maps it into the complex plane
// two lanes (real, imaginary), one multiply then a bit-serial long division each
// depends on mbe_pkg

module mbe_front #(
   parameter int MAX_SIDE = mbe_pkg::MAX_SIDE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  mbe_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  mbe_pkg::req_type req_data,
   output logic             push,
   output mbe_pkg::job_type push_data,
   input  logic             queue_full
);
   import mbe_pkg::*;

   localparam int LANES  = 2;
   localparam int MAG_W  = WIN_W;
   localparam int PROD_W = MAG_W + COORD_W;
   localparam int CNT_W  = $clog2(PROD_W);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL  = 4'b0010,
      F_DIV  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [SIDE_W-1:0]       side_raw [LANES];
   logic [SIDE_W-1:0]       side_eff [LANES];
   logic [SIDE_W-1:0]       side_m1  [LANES];
   logic [COORD_W-1:0]      idx_raw  [LANES];
   logic [COORD_W-1:0]      idx_clamp[LANES];
   logic signed [WIN_W-1:0] lo_raw   [LANES];
   logic signed [WIN_W-1:0] hi_raw   [LANES];
   logic signed [Q_W-1:0]   diff     [LANES];
   logic [MAG_W-1:0]        mag      [LANES];
   logic [SIDE_W:0]         trial    [LANES];
   logic                    fits     [LANES];
   logic signed [Q_W-1:0]   quo_s    [LANES];
   logic signed [Q_W-1:0]   coord    [LANES];

   logic [COORD_W-1:0]      idx_ff[LANES], idx_in[LANES];
   logic [SIDE_W-1:0]       div_ff[LANES], div_in[LANES];
   logic                    neg_ff[LANES], neg_in[LANES];
   logic [MAG_W-1:0]        mag_ff[LANES], mag_in[LANES];
   logic signed [WIN_W-1:0] lo_ff [LANES], lo_in [LANES];
   logic [PROD_W-1:0]       quo_ff[LANES], quo_in[LANES];
   logic [SIDE_W-1:0]       rem_ff[LANES], rem_in[LANES];

   // lane inputs, clamping and window span
   always_comb begin
      side_raw[0] = cfg.image_width;
      side_raw[1] = cfg.image_height;
      idx_raw[0]  = req_data.pixel_col;
      idx_raw[1]  = req_data.pixel_row;
      lo_raw[0]   = cfg.real_min;
      hi_raw[0]   = cfg.real_max;
      lo_raw[1]   = cfg.imag_min;
      hi_raw[1]   = cfg.imag_max;
      for (int l = 0; l < LANES; l++) begin
         priority if (side_raw[l] < SIDE_W'(2)) begin
            side_eff[l] = SIDE_W'(2);
         end else if (int'(side_raw[l]) > MAX_SIDE) begin
            side_eff[l] = SIDE_W'(MAX_SIDE);
         end else begin
            side_eff[l] = side_raw[l];
         end
         side_m1[l]   = side_eff[l] - SIDE_W'(1);
         idx_clamp[l] = (SIDE_W'(idx_raw[l]) > side_m1[l]) ?
                        side_m1[l][COORD_W-1:0] : idx_raw[l];
         diff[l]      = Q_W'(hi_raw[l]) - Q_W'(lo_raw[l]);
         mag[l]       = diff[l][Q_W-1] ? MAG_W'(-diff[l]) : MAG_W'(diff[l]);
         trial[l]     = {rem_ff[l], quo_ff[l][PROD_W-1]};
         fits[l]      = trial[l] >= {1'b0, div_ff[l]};
         quo_s[l]     = signed'({1'b0, quo_ff[l][MAG_W-1:0]});
         coord[l]     = Q_W'(lo_ff[l]) + (neg_ff[l] ? -quo_s[l] : quo_s[l]);
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      for (int l = 0; l < LANES; l++) begin
         idx_in[l] = idx_ff[l];
         div_in[l] = div_ff[l];
         neg_in[l] = neg_ff[l];
         mag_in[l] = mag_ff[l];
         lo_in[l]  = lo_ff[l];
         quo_in[l] = quo_ff[l];
         rem_in[l] = rem_ff[l];
      end
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               for (int l = 0; l < LANES; l++) begin
                  idx_in[l] = idx_clamp[l];
                  div_in[l] = side_m1[l];
                  neg_in[l] = diff[l][Q_W-1];
                  mag_in[l] = mag[l];
                  lo_in[l]  = lo_raw[l];
               end
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            for (int l = 0; l < LANES; l++) begin
               quo_in[l] = PROD_W'(mag_ff[l]) * PROD_W'(idx_ff[l]);
               rem_in[l] = '0;
            end
            cnt_in   = '0;
            state_in = F_DIV;
         end
         F_DIV: begin
            for (int l = 0; l < LANES; l++) begin
               rem_in[l] = fits[l] ? SIDE_W'(trial[l] - {1'b0, div_ff[l]}) :
                                     SIDE_W'(trial[l]);
               quo_in[l] = {quo_ff[l][PROD_W-2:0], fits[l]};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         idx_ff[l] <= idx_in[l];
         div_ff[l] <= div_in[l];
         neg_ff[l] <= neg_in[l];
         mag_ff[l] <= mag_in[l];
         lo_ff[l]  <= lo_in[l];
         quo_ff[l] <= quo_in[l];
         rem_ff[l] <= rem_in[l];
      end
   end

   assign req_stall      = (state_ff != F_IDLE);
   assign push           = (state_ff == F_PUSH) && !queue_full;
   assign push_data.c_re = coord[0];
   assign push_data.c_im = coord[1];

endmodule

### rtl/core/mbe_queue.sv
// short request queue between the mapping front end and the iteration back end
// depends on mbe_pkg

module mbe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mbe_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output mbe_pkg::job_type pop_data,
   output logic             empty
);
   import mbe_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_Q = $clog2(QUEUE_DEPTH + 1);

   job_type entry_ff[QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [COUNT_Q-1:0] count_ff, count_in;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_Q'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == COUNT_Q'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ff];

   a_push_room: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue pushed while full");
   a_pop_data: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue popped while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
         count_ff <= COUNT_Q'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

### rtl/core/mbe_back.sv
// back end: escape-time iteration on one shared set of multipliers,
// grey level by shift-subtract division, registered response
// depends on mbe_pkg

module mbe_back #(
   parameter int MAX_ITERATIONS = mbe_pkg::MAX_ITERATIONS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  mbe_pkg::cfg_type cfg,
   input  logic             queue_empty,
   input  mbe_pkg::job_type pop_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mbe_pkg::rsp_type rsp_data
);
   import mbe_pkg::*;

   localparam int PROD_W = 2 * Q_W;
   localparam int R2_W   = 2 * RADIUS_W;
   localparam int SUM_W  = 42;
   localparam int REM_W  = COUNT_W + GREY_W;
   localparam int STEP_W = $clog2(GREY_W);

   typedef enum logic [5:0] {
      B_IDLE  = 6'b000001,
      B_MUL   = 6'b000010,
      B_UPD   = 6'b000100,
      B_SCALE = 6'b001000,
      B_GREY  = 6'b010000,
      B_DONE  = 6'b100000
   } back_state_type;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] x);
      logic signed [Q_W-1:0] r;
      priority if (x > SUM_W'(64'sd2147483647)) begin
         r = 32'sh7FFFFFFF;
      end else if (x < SUM_W'(-64'sd2147483648)) begin
         r = 32'sh80000000;
      end else begin
         r = Q_W'(x);
      end
      return r;
   endfunction

   back_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_data_ff, out_data_in;

   logic signed [Q_W-1:0]    zr_ff, zr_in, zi_ff, zi_in;
   logic signed [Q_W-1:0]    cr_ff, cr_in, ci_ff, ci_in;
   logic signed [PROD_W-1:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [R2_W-1:0]          r2_ff, r2_in;
   logic [COUNT_W-1:0]       limit_ff, limit_in, iter_ff, iter_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [GREY_W-1:0]        quo_ff, quo_in;
   logic [STEP_W-1:0]        step_ff, step_in;

   logic [COUNT_W-1:0]       limit_eff;
   logic [PROD_W-1:0]        mag2;
   logic signed [PROD_W-1:0] re_diff, re_shift, im_shift;
   logic signed [SUM_W-1:0]  re_sum, im_sum;
   logic [REM_W-1:0]         grey_shift;
   logic                     grey_fits;
   logic                     out_write;

   always_comb begin
      priority if (cfg.iteration_limit == '0) begin
         limit_eff = COUNT_W'(1);
      end else if (int'(cfg.iteration_limit) > MAX_ITERATIONS) begin
         limit_eff = COUNT_W'(MAX_ITERATIONS);
      end else begin
         limit_eff = cfg.iteration_limit;
      end
      mag2       = rr_ff + ii_ff;
      re_diff    = rr_ff - ii_ff;
      re_shift   = re_diff >>> 24;
      im_shift   = ri_ff >>> 23;
      re_sum     = SUM_W'(re_shift) + SUM_W'(cr_ff);
      im_sum     = SUM_W'(im_shift) + SUM_W'(ci_ff);
      grey_shift = REM_W'(limit_ff) << step_ff;
      grey_fits  = rem_ff >= grey_shift;
   end

   always_comb begin
      state_in    = state_ff;
      zr_in       = zr_ff;
      zi_in       = zi_ff;
      cr_in       = cr_ff;
      ci_in       = ci_ff;
      rr_in       = rr_ff;
      ii_in       = ii_ff;
      ri_in       = ri_ff;
      r2_in       = r2_ff;
      limit_in    = limit_ff;
      iter_in     = iter_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      pop         = 1'b0;
      out_write   = 1'b0;
      out_data_in = out_data_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               cr_in    = pop_data.c_re;
               ci_in    = pop_data.c_im;
               zr_in    = '0;
               zi_in    = '0;
               iter_in  = '0;
               limit_in = limit_eff;
               r2_in    = R2_W'(cfg.escape_radius) * R2_W'(cfg.escape_radius);
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            rr_in    = zr_ff * zr_ff;
            ii_in    = zi_ff * zi_ff;
            ri_in    = zr_ff * zi_ff;
            state_in = B_UPD;
         end
         B_UPD: begin
            if (mag2 > PROD_W'(r2_ff)) begin
               state_in = B_SCALE;
            end else begin
               zr_in   = sat_q(re_sum);
               zi_in   = sat_q(im_sum);
               iter_in = iter_ff + COUNT_W'(1);
               if (iter_ff + COUNT_W'(1) == limit_ff) begin
                  state_in = B_SCALE;
               end else begin
                  state_in = B_MUL;
               end
            end
         end
         B_SCALE: begin
            rem_in   = (REM_W'(iter_ff) << GREY_W) - REM_W'(iter_ff);
            quo_in   = '0;
            step_in  = STEP_W'(GREY_W - 1);
            state_in = B_GREY;
         end
         B_GREY: begin
            if (grey_fits) begin
               rem_in = rem_ff - grey_shift;
            end
            quo_in  = {quo_ff[GREY_W-2:0], grey_fits};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_write                   = 1'b1;
               out_data_in.iteration_count = iter_ff;
               out_data_in.grey_level      = GREY_W'(255) - quo_ff;
               out_data_in.inside_set      = (iter_ff == limit_ff);
               state_in                    = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      priority if (out_write) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      rr_ff       <= rr_in;
      ii_ff       <= ii_in;
      ri_ff       <= ri_in;
      r2_ff       <= r2_in;
      limit_ff    <= limit_in;
      iter_ff     <= iter_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_iter_room: assert property (@(posedge clock) disable iff (reset)
         (state_ff == B_MUL) |-> (iter_ff < limit_ff))
      else $error("iteration started at or past the limit");
   a_grey_bound: assert property (@(posedge clock) disable iff (reset)
         (state_ff == B_GREY) |-> (rem_ff < {grey_shift, 1'b0}))
      else $error("grey level remainder out of range");
   a_load_clear: assert property (@(posedge clock) disable iff (reset)
         (state_ff == B_IDLE && !queue_empty)
         |=> (state_ff == B_MUL && zr_ff == '0 && zi_ff == '0 && iter_ff == '0))
      else $error("new pixel did not start from zero");

endmodule

### rtl/core/mandelbrot_escape_time_pixel_core.sv
// Escape-time Mandelbrot pixel core. A pixel request is mapped into the complex
// plane in the front end (one multiply, then a 43-step long division per axis, both
// axes side by side, then the queue write), and the front end stalls new requests
// until that write is done. Mapped points wait in a two-entry queue. The back end takes
// one mapped point at a time and passes each iteration through its shared multiply
// and update states, then works out the grey level and the response. A pixel that
// escapes after N iterations takes one more multiply and update pass than one that
// reaches the limit after N, as the escape test costs one more pass. Responses come
// out in request order through an output register, so the next pixel is worked on while
// one waits. Configuration must be written only while the core is idle; the core does
// not enforce this. Depends on mbe_pkg, mbe_front, mbe_queue and mbe_back.

module mandelbrot_escape_time_pixel_core #(
   parameter int MAX_SIDE       = mbe_pkg::MAX_SIDE_DEF,
   parameter int MAX_ITERATIONS = mbe_pkg::MAX_ITERATIONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mbe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mbe_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mbe_pkg::rsp_type                   rsp_data
);
   import mbe_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    push, pop, queue_full, queue_empty;
   job_type push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_wdata[SIDE_W-1:0];
            CSR_IMAGE_HEIGHT:    cfg_in.image_height    = csr_wdata[SIDE_W-1:0];
            CSR_ITERATION_LIMIT: cfg_in.iteration_limit = csr_wdata[COUNT_W-1:0];
            CSR_ESCAPE_RADIUS:   cfg_in.escape_radius   = csr_wdata[RADIUS_W-1:0];
            CSR_REAL_MIN:        cfg_in.real_min        = signed'(csr_wdata[WIN_W-1:0]);
            CSR_REAL_MAX:        cfg_in.real_max        = signed'(csr_wdata[WIN_W-1:0]);
            CSR_IMAG_MIN:        cfg_in.imag_min        = signed'(csr_wdata[WIN_W-1:0]);
            CSR_IMAG_MAX:        cfg_in.imag_max        = signed'(csr_wdata[WIN_W-1:0]);
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbe_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   mbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   mbe_back #(
      .MAX_ITERATIONS (MAX_ITERATIONS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
